// ----- design/clb_pkg.sv -----
// Package for the character display text buffer.
// Holds geometry constants, command codes, word types, control structs and the cell index function.
package clb_pkg;

  localparam int COLUMNS = 16;
  localparam int ROWS    = 2;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int CELL_W  = $clog2(CELLS);

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

  localparam logic [3:0] CMD_CLEAR     = 4'd0;
  localparam logic [3:0] CMD_CLEAR_EOL = 4'd1;
  localparam logic [3:0] CMD_PUT_CHAR  = 4'd2;
  localparam logic [3:0] CMD_UP        = 4'd3;
  localparam logic [3:0] CMD_DOWN      = 4'd4;
  localparam logic [3:0] CMD_RIGHT     = 4'd5;
  localparam logic [3:0] CMD_LEFT      = 4'd6;
  localparam logic [3:0] CMD_SET_POS   = 4'd7;
  localparam logic [3:0] CMD_READ_CELL = 4'd8;

  typedef struct packed {
    logic [3:0] cmd;
    logic [1:0] row;
    logic [4:0] column;
    logic [7:0] char_code;
    logic       write_flag;
  } in_word_t;

  typedef struct packed {
    logic       ok;
    logic       cursor_row;
    logic [3:0] cursor_column;
    logic [7:0] cell_char;
  } out_word_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic load_cell;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_read;
  } ctl_sts_t;

  function automatic logic [CELL_W-1:0] cell_idx(input logic r, input logic [COL_W-1:0] c);
    cell_idx = r ? CELL_W'(COLUMNS) + CELL_W'(c) : CELL_W'(c);
  endfunction

endpackage

// ----- design/clb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module clb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/clb_ctrl.sv -----
// Controller state machine for the text buffer: word handshakes and sequencing.
// Depends on clb_pkg.
module clb_ctrl
  import clb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t ctl,
  input  ctl_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_READ = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   load_out;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    ctl           = '0;
    load_out      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          ctl.exec = 1'b1;
          if (sts.is_read) begin
            state_nxt = ST_READ;
          end else begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        ctl.load_cell = 1'b1;
        load_out      = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/clb_datapath.sv -----
// Datapath of the text buffer: request register, cursor, cell RAM with per-cell valid bits, result word.
// Depends on clb_pkg and clb_ram.
module clb_datapath
  import clb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_data,
  output out_word_t out_data,
  input  ctl_cmd_t  ctl,
  output ctl_sts_t  sts
);

  in_word_t          req_r;
  logic              cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [CELLS-1:0]  valid_r, valid_nxt;
  logic              rd_valid_r;
  logic              res_ok_r, res_ok_nxt;
  logic              res_row_r;
  logic [COL_W-1:0]  res_col_r;
  logic [7:0]        res_cell_r;

  logic              pos_ok;
  logic [COL_W-1:0]  req_col;
  logic [CELL_W-1:0] req_idx;
  logic [CELL_W-1:0] cur_idx;
  logic              wr_en;
  logic [CELL_W-1:0] wr_addr;
  logic              rd_en;
  logic [7:0]        rd_data;

  assign pos_ok  = !req_r.row[1] && ({2'b00, req_r.column} < 7'(COLUMNS));
  assign req_col = COL_W'(req_r.column);
  assign req_idx = cell_idx(req_r.row[0], req_col);
  assign cur_idx = cell_idx(cur_row_r, cur_col_r);
  assign rd_en   = ctl.exec && (req_r.cmd == CMD_READ_CELL);
  assign sts.is_read = (req_r.cmd == CMD_READ_CELL);

  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    valid_nxt   = valid_r;
    res_ok_nxt  = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = cur_idx;
    if (ctl.exec) begin
      unique case (req_r.cmd)
        CMD_CLEAR: begin
          valid_nxt   = '0;
          cur_row_nxt = 1'b0;
          cur_col_nxt = '0;
          res_ok_nxt  = 1'b1;
        end
        CMD_CLEAR_EOL: begin
          for (int i = 0; i < CELLS; i++) begin
            if (((i / COLUMNS) == int'(cur_row_r)) && ((i % COLUMNS) >= int'(cur_col_r))) begin
              valid_nxt[i] = 1'b0;
            end
          end
          res_ok_nxt = 1'b1;
        end
        CMD_PUT_CHAR, CMD_RIGHT: begin
          if (req_r.cmd == CMD_PUT_CHAR) begin
            wr_en            = 1'b1;
            valid_nxt[cur_idx] = 1'b1;
          end
          if (cur_col_r == LAST_COL) begin
            cur_col_nxt = '0;
            cur_row_nxt = !cur_row_r;
          end else begin
            cur_col_nxt = cur_col_r + 1'b1;
          end
          res_ok_nxt = 1'b1;
        end
        CMD_LEFT: begin
          if (cur_col_r == '0) begin
            cur_col_nxt = LAST_COL;
            cur_row_nxt = !cur_row_r;
          end else begin
            cur_col_nxt = cur_col_r - 1'b1;
          end
          res_ok_nxt = 1'b1;
        end
        CMD_UP: begin
          if (cur_row_r) begin
            cur_row_nxt = 1'b0;
            res_ok_nxt  = 1'b1;
          end
        end
        CMD_DOWN: begin
          if (!cur_row_r) begin
            cur_row_nxt = 1'b1;
            res_ok_nxt  = 1'b1;
          end
        end
        CMD_SET_POS: begin
          if (pos_ok) begin
            cur_row_nxt = req_r.row[0];
            cur_col_nxt = req_col;
            res_ok_nxt  = 1'b1;
            if (req_r.write_flag) begin
              wr_en              = 1'b1;
              wr_addr            = req_idx;
              valid_nxt[req_idx] = 1'b1;
            end
          end
        end
        CMD_READ_CELL: begin
          res_ok_nxt = pos_ok;
        end
        default: begin
        end
      endcase
    end
  end

  clb_ram #(
    .WIDTH(8),
    .DEPTH(CELLS)
  ) u_cells (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(req_r.char_code),
    .rd_en  (rd_en),
    .rd_addr(req_idx),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= 1'b0;
      cur_col_r <= '0;
      valid_r   <= '0;
    end else begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      req_r <= in_data;
    end
    if (rd_en) begin
      rd_valid_r <= valid_r[req_idx];
    end
    if (ctl.exec) begin
      res_ok_r   <= res_ok_nxt;
      res_row_r  <= cur_row_nxt;
      res_col_r  <= cur_col_nxt;
      res_cell_r <= 8'h00;
    end
    if (ctl.load_cell) begin
      res_cell_r <= !res_ok_r ? 8'h00 : (rd_valid_r ? rd_data : SPACE_CHAR);
    end
  end

  assign out_data.ok            = res_ok_r;
  assign out_data.cursor_row    = res_row_r;
  assign out_data.cursor_column = 4'(res_col_r);
  assign out_data.cell_char     = res_cell_r;

endmodule

// ----- design/char_lcd_text_buffer_unit.sv -----
// Top level of the 2-row character display text buffer with cursor.
// Sequence: a command word is latched in the request register, then executed in EXEC, then for a cell read
// loaded from the RAM read port in READ before the result word is registered; EXEC waits for a free result.
// A new word is taken only in IDLE, after the previous one is through; input is taken while a result waits.
// Reset (rst_n, synchronous): all cells read as spaces, cursor at row 0 column 0, no pending word.
module char_lcd_text_buffer_unit
  import clb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  clb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ctl      (ctl),
    .sts      (sts)
  );

  clb_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .out_data(out_data),
    .ctl     (ctl),
    .sts     (sts)
  );

endmodule

// ----- tb/tb_char_lcd_text_buffer_unit.sv -----
// Self-checking testbench for the 2x16 character display text buffer with cursor.
// Depends on clb_pkg for word types and command codes; predicts every result word from its own copy
// of the cells and cursor, or takes the typed result of a directed word, and checks it in order.
`timescale 1ns / 100ps

module tb_char_lcd_text_buffer_unit;
  import clb_pkg::*;

  localparam logic [3:0] CMD_SPARE_LO = 4'd9;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;
  localparam int RANDOM_PER_PHASE = 367;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam out_word_t NO_TYPED = '0;

  typedef struct {
    in_word_t  word;
    bit        typed_en;
    out_word_t typed;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  logic [7:0]       disp_cells [CELLS];
  logic             disp_row;
  logic [COL_W-1:0] disp_col;

  out_word_t pending_results [$];
  stim_row_t directed_rows [$];
  bit        cur_typed_en;
  out_word_t cur_typed;
  out_word_t predicted;
  out_word_t want;

  int send_idle_pct;
  int recv_idle_pct;
  int err_count;
  int words_sent;
  int results_checked;
  int cell_reads;
  int rejected;
  int quiet_cycles;

  char_lcd_text_buffer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic void cursor_right();
    if (disp_col == LAST_COL) begin
      disp_col = '0;
      disp_row = ~disp_row;
    end else begin
      disp_col = disp_col + 1'b1;
    end
  endfunction

  function automatic out_word_t next_display_result(input in_word_t w);
    out_word_t r;
    bit        pos_ok;
    r = '0;
    pos_ok = (w.row < ROWS) && (w.column < COLUMNS);
    case (w.cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) disp_cells[i] = SPACE_CHAR;
        disp_row = 1'b0;
        disp_col = '0;
        r.ok = 1'b1;
      end
      CMD_CLEAR_EOL: begin
        for (int c = disp_col; c < COLUMNS; c++) disp_cells[disp_row * COLUMNS + c] = SPACE_CHAR;
        r.ok = 1'b1;
      end
      CMD_PUT_CHAR: begin
        disp_cells[disp_row * COLUMNS + disp_col] = w.char_code;
        cursor_right();
        r.ok = 1'b1;
      end
      CMD_UP: begin
        if (disp_row) begin
          disp_row = 1'b0;
          r.ok = 1'b1;
        end
      end
      CMD_DOWN: begin
        if (!disp_row) begin
          disp_row = 1'b1;
          r.ok = 1'b1;
        end
      end
      CMD_RIGHT: begin
        cursor_right();
        r.ok = 1'b1;
      end
      CMD_LEFT: begin
        if (disp_col == 0) begin
          disp_col = LAST_COL;
          disp_row = ~disp_row;
        end else begin
          disp_col = disp_col - 1'b1;
        end
        r.ok = 1'b1;
      end
      CMD_SET_POS: begin
        if (pos_ok) begin
          disp_row = w.row[0];
          disp_col = w.column[COL_W-1:0];
          if (w.write_flag) disp_cells[w.row[0] * COLUMNS + w.column] = w.char_code;
          r.ok = 1'b1;
        end
      end
      CMD_READ_CELL: begin
        if (pos_ok) begin
          r.cell_char = disp_cells[w.row[0] * COLUMNS + w.column];
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.cursor_row = disp_row;
    r.cursor_column = disp_col;
    return r;
  endfunction

  function automatic in_word_t random_command();
    in_word_t w;
    int       sel;
    sel = $urandom_range(0, 99);
    w.row = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
    w.column = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31)) : 5'($urandom_range(0, 15));
    w.char_code = 8'($urandom_range(0, 255));
    w.write_flag = 1'($urandom_range(0, 1));
    if (sel < 3) w.cmd = CMD_CLEAR;
    else if (sel < 8) w.cmd = CMD_CLEAR_EOL;
    else if (sel < 38) w.cmd = CMD_PUT_CHAR;
    else if (sel < 43) w.cmd = CMD_UP;
    else if (sel < 48) w.cmd = CMD_DOWN;
    else if (sel < 56) w.cmd = CMD_RIGHT;
    else if (sel < 64) w.cmd = CMD_LEFT;
    else if (sel < 80) w.cmd = CMD_SET_POS;
    else if (sel < 96) w.cmd = CMD_READ_CELL;
    else w.cmd = 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    return w;
  endfunction

  function automatic void add_directed(input in_word_t w, input bit en, input out_word_t fx);
    stim_row_t r;
    r.word = w;
    r.typed_en = en;
    r.typed = fx;
    directed_rows.push_back(r);
  endfunction

  task automatic send_word(input in_word_t w, input bit en, input out_word_t fx);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    cur_typed_en <= en;
    cur_typed <= fx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, out_data);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.ok !== want.ok) begin
            $display("%0t: ok expected %0h actual %0h", $time, want.ok, out_data.ok);
            err_count++;
          end
          if (out_data.cursor_row !== want.cursor_row) begin
            $display("%0t: cursor_row expected %0h actual %0h", $time, want.cursor_row,
                     out_data.cursor_row);
            err_count++;
          end
          if (out_data.cursor_column !== want.cursor_column) begin
            $display("%0t: cursor_column expected %0h actual %0h", $time,
                     want.cursor_column, out_data.cursor_column);
            err_count++;
          end
          if (out_data.cell_char !== want.cell_char) begin
            $display("%0t: cell_char expected %0h actual %0h", $time, want.cell_char,
                     out_data.cell_char);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predicted = next_display_result(in_data);
        pending_results.push_back(cur_typed_en ? cur_typed : predicted);
        words_sent++;
        if (in_data.cmd == CMD_READ_CELL) cell_reads++;
        if (!predicted.ok) rejected++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: no word moved for %0d cycles, %0d results pending", $time,
                   quiet_cycles, pending_results.size());
          $display("char_lcd_text_buffer_unit verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    in_word_t w;
    int       n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cur_typed_en = 1'b0;
    cur_typed = '0;
    err_count = 0;
    words_sent = 0;
    results_checked = 0;
    cell_reads = 0;
    rejected = 0;
    quiet_cycles = 0;
    send_idle_pct = 9;
    recv_idle_pct = 78;
    for (int i = 0; i < CELLS; i++) disp_cells[i] = SPACE_CHAR;
    disp_row = 1'b0;
    disp_col = '0;

    add_directed('{CMD_READ_CELL, 2'd0, 5'd0, 8'h00, 1'b0}, 1, '{1'b1, 1'b0, 4'd0, 8'h20});
    add_directed('{CMD_UP, 2'd0, 5'd0, 8'h00, 1'b0}, 1, '{1'b0, 1'b0, 4'd0, 8'h00});
    add_directed('{CMD_LEFT, 2'd0, 5'd0, 8'h00, 1'b0}, 1, '{1'b1, 1'b1, 4'd15, 8'h00});
    add_directed('{CMD_RIGHT, 2'd0, 5'd0, 8'h00, 1'b0}, 1, '{1'b1, 1'b0, 4'd0, 8'h00});
    add_directed('{CMD_DOWN, 2'd0, 5'd0, 8'h00, 1'b0}, 1, '{1'b1, 1'b1, 4'd0, 8'h00});
    add_directed('{CMD_DOWN, 2'd0, 5'd0, 8'h00, 1'b0}, 1, '{1'b0, 1'b1, 4'd0, 8'h00});
    add_directed('{CMD_UP, 2'd0, 5'd0, 8'h00, 1'b0}, 1, '{1'b1, 1'b0, 4'd0, 8'h00});
    add_directed('{CMD_SET_POS, 2'd3, 5'd31, 8'hFF, 1'b1}, 1, '{1'b0, 1'b0, 4'd0, 8'h00});
    add_directed('{CMD_SET_POS, 2'd2, 5'd0, 8'h00, 1'b0}, 1, '{1'b0, 1'b0, 4'd0, 8'h00});
    add_directed('{CMD_SET_POS, 2'd1, 5'd16, 8'hFF, 1'b1}, 1, '{1'b0, 1'b0, 4'd0, 8'h00});
    add_directed('{CMD_SET_POS, 2'd1, 5'd15, 8'hFF, 1'b1}, 1, '{1'b1, 1'b1, 4'd15, 8'h00});
    add_directed('{CMD_READ_CELL, 2'd1, 5'd15, 8'h00, 1'b0}, 1, '{1'b1, 1'b1, 4'd15, 8'hFF});
    add_directed('{CMD_PUT_CHAR, 2'd0, 5'd0, 8'h00, 1'b0}, 1, '{1'b1, 1'b0, 4'd0, 8'h00});
    add_directed('{CMD_READ_CELL, 2'd1, 5'd15, 8'hFF, 1'b1}, 1, '{1'b1, 1'b0, 4'd0, 8'h00});
    add_directed('{CMD_READ_CELL, 2'd3, 5'd31, 8'h00, 1'b0}, 1, '{1'b0, 1'b0, 4'd0, 8'h00});
    add_directed('{CMD_SET_POS, 2'd0, 5'd8, 8'hA5, 1'b1}, 1, '{1'b1, 1'b0, 4'd8, 8'h00});
    add_directed('{CMD_PUT_CHAR, 2'd3, 5'd31, 8'h5A, 1'b1}, 0, NO_TYPED);
    add_directed('{CMD_SET_POS, 2'd0, 5'd4, 8'h00, 1'b0}, 0, NO_TYPED);
    add_directed('{CMD_CLEAR_EOL, 2'd0, 5'd0, 8'h00, 1'b0}, 0, NO_TYPED);
    add_directed('{CMD_READ_CELL, 2'd0, 5'd8, 8'h00, 1'b0}, 0, NO_TYPED);
    add_directed('{CMD_SPARE_HI, 2'd3, 5'd31, 8'hFF, 1'b1}, 1, '{1'b0, 1'b0, 4'd4, 8'h00});
    add_directed('{CMD_SET_POS, 2'd1, 5'd15, 8'h7E, 1'b1}, 0, NO_TYPED);
    add_directed('{CMD_CLEAR_EOL, 2'd0, 5'd0, 8'h00, 1'b0}, 0, NO_TYPED);
    add_directed('{CMD_READ_CELL, 2'd1, 5'd15, 8'h00, 1'b0}, 1, '{1'b1, 1'b1, 4'd15, 8'h20});
    add_directed('{CMD_CLEAR, 2'd3, 5'd31, 8'hFF, 1'b1}, 1, '{1'b1, 1'b0, 4'd0, 8'h00});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].typed_en, directed_rows[i].typed);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 78 : 0;
      recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 9 : 0;
      n = 0;
      while (n < RANDOM_PER_PHASE) begin
        w = random_command();
        send_word(w, 1'b0, NO_TYPED);
        if (w.cmd <= CMD_READ_CELL) n++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d command words, %0d results checked, %0d cell reads, %0d rejected",
             words_sent, results_checked, cell_reads, rejected);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("char_lcd_text_buffer_unit verification clean");
    end else begin
      $display("char_lcd_text_buffer_unit verification failed");
    end
    $finish;
  end

endmodule
